>>> sv/binary_to_decimal_ascii_defines.svh
// Assertion macros used by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define B2DA_ASSERT_RESET(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/b2da_pkg.sv
package b2da_pkg;

   localparam int RADIX       = 10;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 6;

   // ASCII '0' truncated to the character width
   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 6'd48;
   // Double-dabble correction: add three to any digit of five or more
   localparam logic [DIGIT_WIDTH-1:0] BCD_LIMIT  = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] BCD_ADD    = 4'd3;

   // Number of decimal digits of the largest value of the given width
   function automatic int num_digits(input int width);
      longint unsigned v;
      int              n;
      v = (64'd1 << width) - 64'd1;
      n = 0;
      for (int i = 0; i < 20; i++) begin
         if (v != 64'd0) begin
            v = v / RADIX;
            n = n + 1;
         end
      end
      return n;
   endfunction

endpackage

>>> sv/b2da_dabble.sv
module b2da_dabble #(
   parameter int VALUE_WIDTH = 16,
   parameter int DIGITS      = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [VALUE_WIDTH-1:0]                value,
   output logic                                  done,
   output logic [DIGITS*b2da_pkg::DIGIT_WIDTH-1:0] bcd
);
   import b2da_pkg::*;

   localparam int BCD_WIDTH = DIGITS * DIGIT_WIDTH;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]   adj;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   // Correct every digit before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH] >= BCD_LIMIT) begin
            adj[d*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH] + BCD_ADD;
         end else begin
            adj[d*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[d*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   // Load on start, then shift one binary bit into the digits per cycle
   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         cnt_in  = CNT_WIDTH'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

>>> sv/b2da_emit.sv
module b2da_emit #(
   parameter int DIGITS = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    load,
   input  logic [DIGITS*b2da_pkg::DIGIT_WIDTH-1:0] bcd,
   output logic                                    busy,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]         out_char,
   output logic                                    out_last
);
   import b2da_pkg::*;

   localparam int BCD_WIDTH  = DIGITS * DIGIT_WIDTH;
   localparam int LEFT_WIDTH = $clog2(DIGITS + 1);

   logic [BCD_WIDTH-1:0]   dig_ff, dig_in;
   logic [LEFT_WIDTH-1:0]  left_ff, left_in;
   logic                   lead_ff, lead_in;
   logic                   busy_ff, busy_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic [DIGIT_WIDTH-1:0] top;
   logic                   is_last;
   logic                   skip;
   logic                   out_free;

   assign top      = dig_ff[BCD_WIDTH-1 -: DIGIT_WIDTH];
   assign is_last  = (left_ff == LEFT_WIDTH'(1));
   assign skip     = lead_ff && (top == '0) && !is_last;
   assign out_free = !valid_ff || out_ready;

   // Walk the digits from the top: drop leading zeros, send the rest
   always_comb begin
      dig_in   = dig_ff;
      left_in  = left_ff;
      lead_in  = lead_ff;
      busy_in  = busy_ff;
      valid_in = valid_ff && !out_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         dig_in  = bcd;
         left_in = LEFT_WIDTH'(DIGITS);
         lead_in = 1'b1;
         busy_in = 1'b1;
      end else if (busy_ff && (skip || out_free)) begin
         dig_in  = {dig_ff[BCD_WIDTH-DIGIT_WIDTH-1:0], {DIGIT_WIDTH{1'b0}}};
         left_in = left_ff - 1'b1;
         if (is_last) begin
            busy_in = 1'b0;
         end
         if (!skip) begin
            lead_in  = 1'b0;
            valid_in = 1'b1;
            char_in  = ASCII_ZERO + CHAR_WIDTH'(top);
            last_in  = is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
      dig_ff  <= dig_in;
      left_ff <= left_in;
      lead_ff <= lead_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy      = busy_ff;
   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

>>> sv/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// The req channel takes one unsigned number per beat (low VALUE_WIDTH bits
// of req_tdata). The rsp channel returns its decimal text, one ASCII digit
// per beat, most significant first, without leading zeros; rsp_tlast marks
// the units digit. Zero gives the single character '0'.
// Conversion is double dabble: one binary bit is shifted into the decimal
// digits per cycle. The finished digits are then handed to the serializer,
// which takes one digit position per cycle while rsp does not stall
// (leading zeros are dropped, one per cycle, even during a stall).
// When the serializer has finished, the control returns to idle. DIGITS
// is 5 at the default width.
// One number is in flight at a time; req_tready rises again the cycle after
// the last digit enters the output register, even if rsp has not taken it.
// A stalled rsp holds the current beat; the serializer then only drops leading zeros.
// Reset (synchronous) drops any number in flight and clears rsp_tvalid.
module binary_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      req_tdata,  // [VALUE_WIDTH-1:0] value
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [7:0]                            rsp_tdata,  // [5:0] digit_char
   output logic                                  rsp_tlast   // last_digit
);
   import b2da_pkg::*;

   localparam int DIGITS    = num_digits(VALUE_WIDTH);
   localparam int BCD_WIDTH = DIGITS * DIGIT_WIDTH;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic                  req_fire;
   logic                  conv_done;
   logic [BCD_WIDTH-1:0]  bcd;
   logic                  emit_busy;
   logic [CHAR_WIDTH-1:0] rsp_char;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Sequence: take a number, convert it, serialize it
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (conv_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!emit_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   b2da_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .value (req_tdata[VALUE_WIDTH-1:0]),
      .done  (conv_done),
      .bcd   (bcd)
   );

   b2da_emit #(
      .DIGITS (DIGITS)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (conv_done),
      .bcd       (bcd),
      .busy      (emit_busy),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (rsp_char),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_char};

endmodule

>>> sv/b2da_checker.sv
`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // A stalled beat holds
   `B2DA_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp beat changed while stalled")

   // Every beat carries an ASCII decimal digit
   `B2DA_ASSERT_NOW(a_rsp_digit, rsp_tvalid, (rsp_tdata[7:6] == 2'b00) && (rsp_tdata[5:0] >= 6'd48) && (rsp_tdata[5:0] <= 6'd57), "rsp beat is not a decimal digit")

   // Once a number is taken the block is busy converting it
   `B2DA_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, !req_tready, "input ready while a number is in conversion")

   // Reset leaves no result pending
   `B2DA_ASSERT_RESET(a_reset_idle, reset, !rsp_tvalid && req_tready, "result or busy state survived reset")

endmodule

bind binary_to_decimal_ascii b2da_checker u_checker (.*);

>>> tb/tb_binary_to_decimal_ascii.sv
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
   import b2da_pkg::*;

   localparam int VALUE_WIDTH = 16;
   localparam int REQ_BITS    = ((VALUE_WIDTH + 7) / 8) * 8;
   localparam int WAIT_MAX    = 19;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   // One expected output character with its units-digit flag
   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } digit_beat_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;   // [15:0] value
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;        // [5:0] digit_char
   logic                rsp_tlast;        // last_digit

   logic [VALUE_WIDTH-1:0] numbers_pending[$];
   digit_beat_type         chars_due[$];

   int  n_queued = 0;
   int  n_accepted = 0;
   int  n_beats = 0;
   int  n_mismatch = 0;
   int  n_long_holds = 0;
   int  cycle_count = 0;
   int  hold_requests = 0;
   int  holds_done = 0;
   bit  req_idle_en = 1'b0;
   bit  rsp_idle_en = 1'b0;
   int  len_seen[1:5];

   binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Decimal text of one number, most significant digit first
   function automatic void push_decimal_chars(input logic [VALUE_WIDTH-1:0] value);
      logic [3:0]             dig[10];
      logic [VALUE_WIDTH-1:0] v;
      int                     n;
      v = value;
      n = 0;
      if (v == '0) begin
         chars_due.push_back('{ch: ASCII_ZERO, last: 1'b1});
         len_seen[1]++;
         return;
      end
      while (v != '0) begin
         dig[n] = 4'(v % RADIX);
         v      = v / RADIX;
         n++;
      end
      len_seen[n]++;
      for (int k = n - 1; k >= 0; k--)
         chars_due.push_back('{ch: ASCII_ZERO + CHAR_WIDTH'(dig[k]), last: (k == 0)});
   endfunction

   // Pick a value, mostly with a chosen count of decimal digits
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int lo;
      int hi;
      int d;
      if ($urandom_range(0, 3) == 0)
         return VALUE_WIDTH'($urandom);
      d  = $urandom_range(1, 5);
      lo = (d == 1) ? 0 : 10 ** (d - 1);
      hi = (d == 5) ? 65535 : 10 ** d - 1;
      return VALUE_WIDTH'($urandom_range(lo, hi));
   endfunction

   task automatic queue_number(input logic [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      numbers_pending.push_back(value);
      n_queued++;
   endtask

   task automatic wait_all_done();
      while (!(n_accepted == n_queued && chars_due.size() == 0))
         @(posedge clock);
   endtask

   // Sender: offer queued numbers, idle between beats when enabled
   always @(posedge clock) begin
      int  gap_left;
      bit  offering;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         offering = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            push_decimal_chars(req_tdata[VALUE_WIDTH-1:0]);
            n_accepted++;
            gap_left = req_idle_en ? $urandom_range(0, WAIT_MAX) : 0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (numbers_pending.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= REQ_BITS'(numbers_pending.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each digit beat, stall at random or for a long hold
   always @(posedge clock) begin
      int             wait_left;
      int             hold_left;
      digit_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         wait_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_beats++;
            if (chars_due.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= REPORT_MAX)
                  $display("unexpected digit beat: data 0x%02h last %0b",
                           rsp_tdata, rsp_tlast);
            end else begin
               want = chars_due.pop_front();
               if (rsp_tdata !== {2'b00, want.ch} || rsp_tlast !== want.last) begin
                  n_mismatch++;
                  if (n_mismatch <= REPORT_MAX)
                     $display("digit mismatch at beat %0d: %s 0x%02h last %0b, %s 0x%02h last %0b",
                              n_beats, "expected", {2'b00, want.ch}, want.last,
                              "got", rsp_tdata, rsp_tlast);
               end
            end
            wait_left = rsp_idle_en ? $urandom_range(0, WAIT_MAX) : 0;
         end
         if (holds_done < hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (wait_left > 0) begin
            wait_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d numbers accepted", cycle_count, n_accepted);
      $display("[binary_to_decimal_ascii] ERROR");
      $finish;
   end

   initial begin
      logic [VALUE_WIDTH-1:0] corners[$];
      for (int i = 1; i <= 5; i++) len_seen[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero, digit-count boundaries, all-ones and bit patterns
      corners = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
                  16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd255, 16'd256,
                  16'd12345, 16'd50000, 16'd10001, 16'h8000, 16'h5555, 16'hAAAA,
                  16'd60000, 16'd90, 16'd1};
      foreach (corners[i]) queue_number(corners[i]);
      wait_all_done();

      // Random with idling on both sides
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      repeat (80) queue_number(pick_value());
      wait_all_done();

      // Random back to back, no idling
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (70) queue_number(pick_value());
      wait_all_done();

      // Long receiver hold while the sender keeps offering
      hold_requests++;
      n_long_holds++;
      repeat (15) queue_number(pick_value());
      wait_all_done();

      // Idle on one side at a time, then both
      req_idle_en = 1'b1;
      repeat (40) queue_number(pick_value());
      wait_all_done();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b1;
      repeat (40) queue_number(pick_value());
      wait_all_done();
      req_idle_en = 1'b1;
      repeat (35) queue_number(pick_value());
      wait_all_done();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("converted %0d numbers into %0d digit beats, %0d long output hold(s)",
               n_accepted, n_beats, n_long_holds);
      $display("numbers by digit count 1..5: %0d %0d %0d %0d %0d, mismatches %0d",
               len_seen[1], len_seen[2], len_seen[3], len_seen[4], len_seen[5], n_mismatch);
      if (n_mismatch == 0 && chars_due.size() == 0)
         $display("[binary_to_decimal_ascii] OK");
      else
         $display("[binary_to_decimal_ascii] ERROR");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/b2da_pkg.sv
sv/b2da_dabble.sv
sv/b2da_emit.sv
sv/binary_to_decimal_ascii.sv
sv/b2da_checker.sv
tb/tb_binary_to_decimal_ascii.sv
